// ----- rtl/core/gat_pkg.sv -----
// Shared types, codes and constants of the group aggregate table.
package gat_pkg;

  localparam int MaxGroups  = 1024;
  localparam int TableDepth = 1024;
  localparam int Capacity   = (MaxGroups < TableDepth) ? MaxGroups : TableDepth;
  localparam int IdxW       = 10;
  localparam int GcW        = 11;
  localparam int AccW       = 64;
  localparam int CntW       = 32;
  localparam int ValW       = 32;
  localparam int FracW      = 16;
  localparam int DvdW       = AccW + FracW;
  localparam int DivCntW    = 7;

  typedef enum logic [2:0] {
    KindCount = 3'd0,
    KindSum   = 3'd1,
    KindAvg   = 3'd2,
    KindMin   = 3'd3,
    KindMax   = 3'd4
  } agg_kind_e;

  typedef enum logic [1:0] {
    ReqAdd    = 2'd0,
    ReqUpdate = 2'd1,
    ReqRead   = 2'd2,
    ReqNone   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StUnknown = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StDiv,
    StFin,
    StResp
  } state_e;

  typedef struct packed {
    logic rd;
    logic exec;
    logic div_step;
    logic div_fin;
    logic load_out;
  } gat_cmd_t;

  typedef struct packed {
    logic avg_div;
    logic div_last;
    logic out_free;
  } gat_sts_t;

  // Codes 5 to 7 fold to count
  function automatic agg_kind_e kind_decode(input logic [2:0] raw);
    agg_kind_e k;
    k = KindCount;
    if (raw == KindSum) k = KindSum;
    if (raw == KindAvg) k = KindAvg;
    if (raw == KindMin) k = KindMin;
    if (raw == KindMax) k = KindMax;
    return k;
  endfunction

endpackage

// ----- rtl/core/gat_if.sv -----
// Request and response channel interfaces of the group aggregate table.
interface gat_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [gat_pkg::IdxW-1:0]   group_sel;
  logic signed [gat_pkg::ValW-1:0] value;
  modport source (output valid, req_type, group_sel, value, input ready);
  modport sink   (input valid, req_type, group_sel, value, output ready);
endinterface

interface gat_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [gat_pkg::IdxW-1:0]   result_group;
  logic signed [gat_pkg::AccW-1:0] result_value;
  modport source (output valid, status, result_group, result_value, input ready);
  modport sink   (input valid, status, result_group, result_value, output ready);
endinterface

// ----- rtl/core/gat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gat_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/core/gat_ctrl.sv -----
// Controller state machine of the group aggregate table.
module gat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gat_pkg::gat_sts_t sts_i,
  output gat_pkg::gat_cmd_t cmd_o
);
  import gat_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.rd = 1'b1;
          state_d  = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.avg_div ? StDiv : StResp;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.div_fin = 1'b1;
        state_d       = StResp;
      end
      StResp: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StExec))
    else $error("accepted transaction did not move to execute");
  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) |=> (state_q == StDiv || state_q == StResp))
    else $error("execute held for more than one cycle");
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && sts_i.div_last) |=> (state_q == StFin))
    else $error("divider end missed");
`endif
endmodule

// ----- rtl/core/gat_dp.sv -----
// Datapath of the group aggregate table: tables, folding logic and divider.
module gat_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_wdata_i,
  input  logic [1:0]                   req_type_i,
  input  logic [gat_pkg::IdxW-1:0]     group_sel_i,
  input  logic signed [gat_pkg::ValW-1:0] value_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   status_o,
  output logic [gat_pkg::IdxW-1:0]     result_group_o,
  output logic signed [gat_pkg::AccW-1:0] result_value_o,
  input  gat_pkg::gat_cmd_t            cmd_i,
  output gat_pkg::gat_sts_t            sts_o
);
  import gat_pkg::*;

  logic [2:0]        kind_q;
  logic [GcW-1:0]    gc_q;
  logic [1:0]        req_q;
  logic [IdxW-1:0]   idx_q;
  logic [AccW-1:0]   val_q;
  logic [AccW-1:0]   acc_rd;
  logic [CntW-1:0]   rc_rd;
  logic              acc_we, rc_we;
  logic [IdxW-1:0]   waddr;
  logic [AccW-1:0]   acc_wd;
  logic [CntW-1:0]   rc_wd;
  agg_kind_e         kind;
  logic              unknown, full;
  logic [1:0]        res_status_q;
  logic [IdxW-1:0]   res_group_q;
  logic [AccW-1:0]   res_value_q;
  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [IdxW-1:0]   out_group_q;
  logic [AccW-1:0]   out_value_q;
  logic [DvdW-1:0]   dvd_q;
  logic [CntW-1:0]   rem_q;
  logic [CntW-1:0]   dsr_q;
  logic              neg_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [CntW:0]     trial;
  logic [CntW:0]     diff;
  logic [AccW-1:0]   mag;
  logic [AccW-1:0]   avg_res;

  assign kind    = kind_decode(kind_q);
  assign unknown = ({1'b0, idx_q} >= gc_q);
  assign full    = (gc_q >= GcW'(Capacity));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindCount;
    end else if (cfg_we_i) begin
      kind_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      req_q <= req_type_i;
      idx_q <= group_sel_i;
      val_q <= AccW'(value_i);
    end
  end

  gat_ram #(.Width(AccW), .Depth(TableDepth)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (waddr),
    .wdata_i (acc_wd),
    .re_i    (cmd_i.rd),
    .raddr_i (group_sel_i),
    .rdata_o (acc_rd)
  );

  gat_ram #(.Width(CntW), .Depth(TableDepth)) u_rc_ram (
    .clk_i   (clk_i),
    .we_i    (rc_we),
    .waddr_i (waddr),
    .wdata_i (rc_wd),
    .re_i    (cmd_i.rd),
    .raddr_i (group_sel_i),
    .rdata_o (rc_rd)
  );

  always_comb begin
    acc_we = 1'b0;
    rc_we  = 1'b0;
    waddr  = idx_q;
    acc_wd = acc_rd;
    rc_wd  = (rc_rd == '1) ? rc_rd : rc_rd + CntW'(1);
    if (cmd_i.exec) begin
      if (req_q == ReqAdd) begin
        waddr  = gc_q[IdxW-1:0];
        acc_wd = (kind == KindCount) ? AccW'(1) : val_q;
        rc_wd  = CntW'(1);
        acc_we = !full;
        rc_we  = !full;
      end else if (req_q == ReqUpdate && !unknown) begin
        acc_we = 1'b1;
        rc_we  = (kind == KindAvg);
        unique case (kind)
          KindSum, KindAvg: acc_wd = acc_rd + val_q;
          KindMin: acc_wd = ($signed(val_q) < $signed(acc_rd)) ? val_q : acc_rd;
          KindMax: acc_wd = ($signed(acc_rd) < $signed(val_q)) ? val_q : acc_rd;
          default: acc_wd = acc_rd + AccW'(1);
        endcase
      end
    end
  end

  assign sts_o.avg_div  = (req_q == ReqRead) && !unknown && (kind == KindAvg) && (rc_rd != '0);
  assign sts_o.div_last = (div_cnt_q == DivCntW'(1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_q <= '0;
    end else if (cmd_i.exec && req_q == ReqAdd && !full) begin
      gc_q <= gc_q + GcW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      priority if (req_q == ReqAdd) begin
        res_status_q <= full ? StFull : StOk;
        res_group_q  <= full ? '0 : gc_q[IdxW-1:0];
        res_value_q  <= '0;
      end else if (req_q != ReqNone && unknown) begin
        res_status_q <= StUnknown;
        res_group_q  <= idx_q;
        res_value_q  <= '0;
      end else begin
        res_status_q <= StOk;
        res_group_q  <= idx_q;
        res_value_q  <= (req_q == ReqRead && kind != KindAvg) ? acc_rd : '0;
      end
    end else if (cmd_i.div_fin) begin
      res_value_q <= avg_res;
    end
  end

  // Restoring divider, one quotient bit per cycle
  assign mag   = acc_rd[AccW-1] ? (AccW'(0) - acc_rd) : acc_rd;
  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.exec && sts_o.avg_div) begin
      div_cnt_q <= DivCntW'(DvdW);
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && sts_o.avg_div) begin
      dvd_q <= {mag, FracW'(0)};
      rem_q <= '0;
      dsr_q <= rc_rd;
      neg_q <= acc_rd[AccW-1];
    end else if (cmd_i.div_step) begin
      if (!diff[CntW]) begin
        rem_q <= diff[CntW-1:0];
        dvd_q <= {dvd_q[DvdW-2:0], 1'b1};
      end else begin
        rem_q <= trial[CntW-1:0];
        dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (!neg_q) begin
      avg_res = (dvd_q[DvdW-1:AccW-1] != '0) ? {1'b0, {(AccW-1){1'b1}}} : dvd_q[AccW-1:0];
    end else if (dvd_q[DvdW-1:AccW] != '0 || (dvd_q[AccW-1] && dvd_q[AccW-2:0] != '0)) begin
      avg_res = {1'b1, {(AccW-1){1'b0}}};
    end else begin
      avg_res = AccW'(0) - dvd_q[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_group_q  <= res_group_q;
      out_value_q  <= res_value_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_group_o = out_group_q;
  assign result_value_o = out_value_q;
endmodule

// ----- rtl/core/group_aggregate_table.sv -----
// Top level of the group aggregate table.
// One aggregate per group (count, sum, average, minimum or maximum, set by
// agg_kind). Transactions are handled one at a time: add, update, plain read,
// refusal and unknown-group responses go through accept, table read,
// execute and response load. An average read also runs, before the response
// load, the bit-serial 80-bit restoring divider with one quotient bit per cycle.
// A finished response waits in an output register while the next transaction
// is accepted. Write agg_kind only while no transaction is in flight.
module group_aggregate_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  gat_req_if.sink    req,
  gat_rsp_if.source  rsp
);
  import gat_pkg::*;

  gat_cmd_t cmd;
  gat_sts_t sts;

  gat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gat_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req.req_type),
    .group_sel_i    (req.group_sel),
    .value_i        (req.value),
    .out_ready_i    (rsp.ready),
    .out_valid_o    (rsp.valid),
    .status_o       (rsp.status),
    .result_group_o (rsp.result_group),
    .result_value_o (rsp.result_value),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );
endmodule
